// ===== hdl/aik_pkg.sv =====
// Shared widths, constants and helper functions for the arm
// inverse kinematics block. No dependencies.

package aik_pkg;

	// Default fraction bits of the internal fixed point angles
	localparam int FRAC_BITS_DEF = 16;

	// Configuration port
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_LINK    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FORE_LINK     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIP_DROP      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ORIGIN  = 2'd1;
	localparam logic [1:0] ST_UNREACH = 2'd2;

	// Arc unit widths
	localparam int C_W      = 24;  // signed cosine term
	localparam int S2_IN_W  = 46;  // squared sine term at entry
	localparam int A_W      = 40;  // normalised cosine magnitude
	localparam int S_W      = 62;  // normalised squared sine term
	localparam int ROOT_W   = 31;  // square root
	localparam int REM_W    = 34;  // square root remainder
	localparam int XY_W     = 44;  // CORDIC vector components
	localparam int A_LIM    = 38;  // normalise until a reaches 2^38
	localparam int S_LIM    = 60;  // or s2 reaches 2^60
	localparam int NORM_STEPS = 5; // binary shift search 16,8,4,2,1
	localparam int SQ_STEPS = ROOT_W;
	localparam int Z_EXTRA  = 10;  // integer bits of an angle, sign included
	localparam int FIN_EXTRA = 12; // integer bits of the summed angles

	// Pipeline stages around the arc units
	localparam int FRONT_STAGES = 5;
	localparam int BACK_STAGES  = 2;

	// atan(2^-i) in degrees, Q.24
	localparam int STEP_TAB_LEN = 28;
	localparam longint STEP_Q24 [STEP_TAB_LEN] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367, 234683, 117342,
		58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
		14, 7
	};

	function automatic int cordic_iters(input int f);
		return (f + 4 < STEP_TAB_LEN) ? f + 4 : STEP_TAB_LEN;
	endfunction

	// step angle rounded half up from Q.24 to Q.f
	function automatic longint step_angle(input int k, input int f);
		longint sh;
		longint half;
		sh = 24 - f;
		half = (sh > 0) ? (longint'(1) << (sh - 1)) : longint'(0);
		return (STEP_Q24[k] + half) >>> sh;
	endfunction

	function automatic int arc_latency(input int f);
		return 1 + NORM_STEPS + SQ_STEPS + 1 + cordic_iters(f) + 1;
	endfunction

	function automatic int block_latency(input int f);
		return FRONT_STAGES + arc_latency(f) + BACK_STAGES;
	endfunction

endpackage

// ===== hdl/arm_inverse_kinematics.sv =====
// Top level of the two-link arm inverse kinematics block: configuration
// registers, law-of-cosines front end, four arc units and angle assembly.
// Depends on aik_pkg and aik_arc.

// One target word is taken at every clock edge where start is high; busy
// stays low, so a new word may follow in each cycle. Each word gives one
// result word on the angle and status ports, marked by done for exactly one
// cycle, once the word has passed five front end stages, the arc unit
// (six normalising stages, 31 square root cells, one turn stage,
// min(FRAC_BITS+4, 28) CORDIC cells and one result stage) and two
// assembly stages.
// done cannot be held off, so the receiver must take every result word.
// Register writes are meant only while no word is in flight.

module arm_inverse_kinematics #(
	parameter int FRAC_BITS = aik_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	output logic                              done,
	input  logic                              cfg_we,
	input  logic [aik_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [aik_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic signed [10:0]                target_x,
	input  logic signed [10:0]                target_y,
	output logic [7:0]                        base_angle,
	output logic signed [8:0]                 shoulder_angle,
	output logic [7:0]                        elbow_angle,
	output logic signed [9:0]                 wrist_angle,
	output logic [1:0]                        status
);

	localparam int LAT   = aik_pkg::block_latency(FRAC_BITS);
	localparam int AL    = aik_pkg::arc_latency(FRAC_BITS);
	localparam int Z_W   = FRAC_BITS + aik_pkg::Z_EXTRA;
	localparam int FIN_W = FRAC_BITS + aik_pkg::FIN_EXTRA;
	localparam int C_W   = aik_pkg::C_W;
	localparam int S2W   = aik_pkg::S2_IN_W;
	localparam logic signed [FIN_W-1:0] D90  = FIN_W'(90 * (longint'(1) << FRAC_BITS));
	localparam logic signed [FIN_W-1:0] D360 = FIN_W'(360 * (longint'(1) << FRAC_BITS));

	typedef struct packed {
		logic       hv_nonpos;
		logic [1:0] status;
	} side_t;

	// truncate toward zero to whole degrees
	function automatic logic signed [11:0] trunc_deg(input logic signed [FIN_W-1:0] v);
		logic signed [FIN_W-1:0] m;
		logic signed [FIN_W-1:0] q;
		m = v[FIN_W-1] ? -v : v;
		q = m >>> FRAC_BITS;
		q = v[FIN_W-1] ? -q : q;
		return q[11:0];
	endfunction

	assign busy = 1'b0;

	// configuration registers
	logic [9:0] base_height_q, upper_link_q, fore_link_q, tip_drop_q;
	logic [9:0] target_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_height_q   <= 10'd110;
			upper_link_q    <= 10'd139;
			fore_link_q     <= 10'd162;
			tip_drop_q      <= 10'd71;
			target_height_q <= 10'h3F1;
		end else if (cfg_we) begin
			case (cfg_addr)
				aik_pkg::REG_BASE_HEIGHT:   base_height_q   <= cfg_wdata;
				aik_pkg::REG_UPPER_LINK:    upper_link_q    <= cfg_wdata;
				aik_pkg::REG_FORE_LINK:     fore_link_q     <= cfg_wdata;
				aik_pkg::REG_TIP_DROP:      tip_drop_q      <= cfg_wdata;
				aik_pkg::REG_TARGET_HEIGHT: target_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// word valid line, one bit per stage
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[LAT-2:0], start};
	end

	assign done = vld_q[LAT-1];

	// stage 1: squares of the inputs and link lengths, vertical offset
	logic signed [21:0] xx_c, yy_c;
	logic signed [11:0] hv_c;
	logic [19:0]        l1sq_c, l2sq_c;

	assign xx_c   = target_x * target_x;
	assign yy_c   = target_y * target_y;
	assign hv_c   = $signed({{2{target_height_q[9]}}, target_height_q})
		+ $signed({2'b00, tip_drop_q}) - $signed({2'b00, base_height_q});
	assign l1sq_c = upper_link_q * upper_link_q;
	assign l2sq_c = fore_link_q * fore_link_q;

	logic signed [10:0] x_s1;
	logic [20:0]        xx_s1, yy_s1;
	logic signed [11:0] hv_s1;
	logic [19:0]        l1sq_s1, l2sq_s1;
	logic               origin_s1, link0_s1;

	always_ff @(posedge clk) begin
		x_s1      <= target_x;
		xx_s1     <= xx_c[20:0];
		yy_s1     <= yy_c[20:0];
		hv_s1     <= hv_c;
		l1sq_s1   <= l1sq_c;
		l2sq_s1   <= l2sq_c;
		origin_s1 <= (target_x == '0) && (target_y == '0);
		link0_s1  <= (upper_link_q == '0) || (fore_link_q == '0);
	end

	// stage 2: r^2, hv^2, l1^2 * l2^2
	logic signed [23:0] hvsq_c;
	assign hvsq_c = hv_s1 * hv_s1;

	logic signed [10:0] x_s2;
	logic [20:0]        yy_s2;
	logic signed [11:0] hv_s2;
	logic [21:0]        r2_s2, hvsq_s2;
	logic [19:0]        l1sq_s2, l2sq_s2;
	logic [39:0]        l12_s2;
	logic               origin_s2, link0_s2;

	always_ff @(posedge clk) begin
		x_s2      <= x_s1;
		yy_s2     <= yy_s1;
		hv_s2     <= hv_s1;
		r2_s2     <= {1'b0, xx_s1} + {1'b0, yy_s1};
		hvsq_s2   <= hvsq_c[21:0];
		l1sq_s2   <= l1sq_s1;
		l2sq_s2   <= l2sq_s1;
		l12_s2    <= l1sq_s1 * l2sq_s1;
		origin_s2 <= origin_s1;
		link0_s2  <= link0_s1;
	end

	// stage 3: squared wrist distance and the law-of-cosines terms
	logic [22:0]           d_c;
	logic signed [C_W-1:0] c1_c, e_c;

	assign d_c  = {1'b0, r2_s2} + {1'b0, hvsq_s2};
	assign c1_c = $signed({4'b0, l1sq_s2}) + $signed({1'b0, d_c}) - $signed({4'b0, l2sq_s2});
	assign e_c  = $signed({4'b0, l1sq_s2}) + $signed({4'b0, l2sq_s2}) - $signed({1'b0, d_c});

	logic signed [10:0]    x_s3;
	logic [20:0]           yy_s3;
	logic signed [11:0]    hv_s3;
	logic [21:0]           r2_s3;
	logic [22:0]           d_s3;
	logic signed [C_W-1:0] c1_s3, e_s3;
	logic [19:0]           l1sq_s3;
	logic [39:0]           l12_s3;
	logic                  origin_s3, link0_s3;

	always_ff @(posedge clk) begin
		x_s3      <= x_s2;
		yy_s3     <= yy_s2;
		hv_s3     <= hv_s2;
		r2_s3     <= r2_s2;
		d_s3      <= d_c;
		c1_s3     <= c1_c;
		e_s3      <= e_c;
		l1sq_s3   <= l1sq_s2;
		l12_s3    <= l12_s2;
		origin_s3 <= origin_s2;
		link0_s3  <= link0_s2;
	end

	// stage 4: products for the two discriminants
	logic signed [47:0] c1sq_c, esq_c;
	assign c1sq_c = c1_s3 * c1_s3;
	assign esq_c  = e_s3 * e_s3;

	logic signed [10:0]    x_s4;
	logic [20:0]           yy_s4;
	logic signed [11:0]    hv_s4;
	logic [21:0]           r2_s4;
	logic signed [C_W-1:0] c1_s4, e_s4;
	logic [42:0]           p1_s4;
	logic [45:0]           c1sq_s4, esq_s4;
	logic [39:0]           l12_s4;
	logic                  origin_s4, link0_s4;

	always_ff @(posedge clk) begin
		x_s4      <= x_s3;
		yy_s4     <= yy_s3;
		hv_s4     <= hv_s3;
		r2_s4     <= r2_s3;
		c1_s4     <= c1_s3;
		e_s4      <= e_s3;
		p1_s4     <= l1sq_s3 * d_s3;
		c1sq_s4   <= c1sq_c[45:0];
		esq_s4    <= esq_c[45:0];
		l12_s4    <= l12_s3;
		origin_s4 <= origin_s3;
		link0_s4  <= link0_s3;
	end

	// stage 5: discriminants and status
	logic signed [46:0] disc1_c, disc2_c;
	logic [1:0]         status_c;

	assign disc1_c = $signed({2'b00, p1_s4, 2'b00}) - $signed({1'b0, c1sq_s4});
	assign disc2_c = $signed({5'b0, l12_s4, 2'b00}) - $signed({1'b0, esq_s4});

	always_comb begin
		if (origin_s4)
			status_c = aik_pkg::ST_ORIGIN;
		else if (link0_s4 || disc1_c[46] || disc2_c[46])
			status_c = aik_pkg::ST_UNREACH;
		else
			status_c = aik_pkg::ST_OK;
	end

	logic signed [10:0]    x_s5;
	logic [20:0]           yy_s5;
	logic [10:0]           habs_s5;
	logic [21:0]           r2_s5;
	logic signed [C_W-1:0] c1_s5, e_s5;
	logic [S2W-1:0]        disc1_s5, disc2_s5;
	side_t                 side_s5;

	always_ff @(posedge clk) begin
		x_s5     <= x_s4;
		yy_s5    <= yy_s4;
		habs_s5  <= hv_s4[11] ? 11'(-hv_s4) : hv_s4[10:0];
		r2_s5    <= r2_s4;
		c1_s5    <= c1_s4;
		e_s5     <= e_s4;
		disc1_s5 <= disc1_c[46] ? '0 : disc1_c[S2W-1:0];
		disc2_s5 <= disc2_c[46] ? '0 : disc2_c[S2W-1:0];
		side_s5  <= '{hv_nonpos: hv_s4[11] || (hv_s4 == '0), status: status_c};
	end

	// four arc units: base, wrist elevation, shoulder, elbow
	logic signed [Z_W-1:0] z_pol, z_elev, z_sh, z_el;

	aik_arc #(.FRAC_BITS(FRAC_BITS)) u_arc_pol (
		.clk (clk),
		.c   ($signed({{(C_W-11){x_s5[10]}}, x_s5})),
		.s2  ({{(S2W-21){1'b0}}, yy_s5}),
		.z   (z_pol)
	);

	aik_arc #(.FRAC_BITS(FRAC_BITS)) u_arc_elev (
		.clk (clk),
		.c   ($signed({{(C_W-11){1'b0}}, habs_s5})),
		.s2  ({{(S2W-22){1'b0}}, r2_s5}),
		.z   (z_elev)
	);

	aik_arc #(.FRAC_BITS(FRAC_BITS)) u_arc_sh (
		.clk (clk),
		.c   (c1_s5),
		.s2  (disc1_s5),
		.z   (z_sh)
	);

	aik_arc #(.FRAC_BITS(FRAC_BITS)) u_arc_el (
		.clk (clk),
		.c   (e_s5),
		.s2  (disc2_s5),
		.z   (z_el)
	);

	// offset sign and status ride alongside the arc units
	side_t side_q [0:AL-1];

	always_ff @(posedge clk) begin
		side_q[0] <= side_s5;
		for (int i = 1; i < AL; i++)
			side_q[i] <= side_q[i-1];
	end

	// assembly 1: shoulder interior angle
	logic signed [FIN_W-1:0] a0_c, a0n_c;
	assign a0_c  = D90 - FIN_W'(z_elev);
	assign a0n_c = side_q[AL-1].hv_nonpos ? -a0_c : a0_c;

	logic signed [FIN_W-1:0] pol_f1, a01_f1, a12_f1;
	side_t                   side_f1;

	always_ff @(posedge clk) begin
		pol_f1  <= FIN_W'(z_pol);
		a01_f1  <= a0n_c + FIN_W'(z_sh) + D90;
		a12_f1  <= FIN_W'(z_el);
		side_f1 <= side_q[AL-1];
	end

	// assembly 2: wrist angle, truncation and complements
	logic signed [FIN_W-1:0] a23_c;
	logic signed [11:0]      t_pol_c, sh_c, el_c, wr_c;
	logic                    ok_c;

	assign a23_c   = D360 - a01_f1 - a12_f1;
	assign t_pol_c = trunc_deg(pol_f1);
	assign sh_c    = 12'sd180 - trunc_deg(a01_f1);
	assign el_c    = 12'sd180 - trunc_deg(a12_f1);
	assign wr_c    = 12'sd180 - trunc_deg(a23_c);
	assign ok_c    = (side_f1.status == aik_pkg::ST_OK);

	always_ff @(posedge clk) begin
		base_angle     <= ok_c ? t_pol_c[7:0] : '0;
		shoulder_angle <= ok_c ? sh_c[8:0] : '0;
		elbow_angle    <= ok_c ? el_c[7:0] : '0;
		wrist_angle    <= ok_c ? wr_c[9:0] : '0;
		status         <= side_f1.status;
	end

endmodule

// ===== hdl/aik_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root.
// Depends on aik_pkg.

module aik_sqrt_cell (
	input  logic                        clk,
	input  logic [aik_pkg::S_W-1:0]     rad_i,
	input  logic [aik_pkg::REM_W-1:0]   rem_i,
	input  logic [aik_pkg::ROOT_W-1:0]  root_i,
	output logic [aik_pkg::S_W-1:0]     rad_o,
	output logic [aik_pkg::REM_W-1:0]   rem_o,
	output logic [aik_pkg::ROOT_W-1:0]  root_o
);

	logic [aik_pkg::REM_W-1:0] rem_c;
	logic [aik_pkg::REM_W-1:0] trial_c;

	// bring down the next two radicand bits and try root*4+1
	assign rem_c   = {rem_i[aik_pkg::REM_W-3:0], rad_i[aik_pkg::S_W-1 -: 2]};
	assign trial_c = aik_pkg::REM_W'({root_i, 2'b01});

	always_ff @(posedge clk) begin
		rad_o <= {rad_i[aik_pkg::S_W-3:0], 2'b00};
		if (rem_c >= trial_c) begin
			rem_o  <= rem_c - trial_c;
			root_o <= {root_i[aik_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			rem_o  <= rem_c;
			root_o <= {root_i[aik_pkg::ROOT_W-2:0], 1'b0};
		end
	end

endmodule

// ===== hdl/aik_cordic_cell.sv =====
// One vectoring step of the pipelined CORDIC angle unit.
// Depends on aik_pkg.

module aik_cordic_cell #(
	parameter int SHIFT = 0,
	parameter int Z_W = aik_pkg::FRAC_BITS_DEF + aik_pkg::Z_EXTRA,
	parameter logic signed [Z_W-1:0] STEP = '0
) (
	input  logic                              clk,
	input  logic signed [aik_pkg::XY_W-1:0]   x_i,
	input  logic signed [aik_pkg::XY_W-1:0]   y_i,
	input  logic signed [Z_W-1:0]             z_i,
	output logic signed [aik_pkg::XY_W-1:0]   x_o,
	output logic signed [aik_pkg::XY_W-1:0]   y_o,
	output logic signed [Z_W-1:0]             z_o
);

	logic signed [aik_pkg::XY_W-1:0] xs_c;
	logic signed [aik_pkg::XY_W-1:0] ys_c;
	logic                            down_c;

	// flooring shifts, turn towards y = 0
	assign xs_c   = x_i >>> SHIFT;
	assign ys_c   = y_i >>> SHIFT;
	assign down_c = !y_i[aik_pkg::XY_W-1] && (y_i != '0);

	always_ff @(posedge clk) begin
		if (down_c) begin
			x_o <= x_i + ys_c;
			y_o <= y_i - xs_c;
			z_o <= z_i + STEP;
		end else begin
			x_o <= x_i - ys_c;
			y_o <= y_i + xs_c;
			z_o <= z_i - STEP;
		end
	end

endmodule

// ===== hdl/aik_arc.sv =====
// Pipelined atan2(sqrt(s2), c) in Q.FRAC_BITS degrees: normalising shift
// search, a chain of square root cells, then a chain of CORDIC cells.
// Depends on aik_pkg, aik_sqrt_cell, aik_cordic_cell.

module aik_arc #(
	parameter int FRAC_BITS = aik_pkg::FRAC_BITS_DEF
) (
	input  logic                                          clk,
	input  logic signed [aik_pkg::C_W-1:0]                c,
	input  logic [aik_pkg::S2_IN_W-1:0]                   s2,
	output logic signed [FRAC_BITS+aik_pkg::Z_EXTRA-1:0]  z
);

	localparam int Z_W   = FRAC_BITS + aik_pkg::Z_EXTRA;
	localparam int ITERS = aik_pkg::cordic_iters(FRAC_BITS);
	localparam int SQ    = aik_pkg::SQ_STEPS;
	localparam int NS    = aik_pkg::NORM_STEPS;
	localparam int A_W   = aik_pkg::A_W;
	localparam int S_W   = aik_pkg::S_W;
	localparam int XY_W  = aik_pkg::XY_W;
	localparam logic signed [Z_W-1:0] D90  = Z_W'(90 * (longint'(1) << FRAC_BITS));
	localparam logic signed [Z_W-1:0] D180 = Z_W'(180 * (longint'(1) << FRAC_BITS));

	typedef enum logic [1:0] {SC_NONE, SC_ZERO, SC_HALF, SC_RIGHT} short_t;

	// room to double a and quadruple s2 by 2^n and stay below the limits
	function automatic logic norm_room(input logic [A_W-1:0] a, input logic [S_W-1:0] s,
			input int n);
		return ((a >> (aik_pkg::A_LIM - n)) == '0) && ((s >> (aik_pkg::S_LIM - 2 * n)) == '0);
	endfunction

	// entry: magnitude, sign and shortcut cases
	logic [aik_pkg::C_W-1:0] mag_c;
	logic [A_W-1:0]          a_c;
	logic [S_W-1:0]          s_c;
	short_t                  code_c;

	assign mag_c = c[aik_pkg::C_W-1] ? aik_pkg::C_W'(-c) : aik_pkg::C_W'(c);
	assign a_c   = A_W'(mag_c);
	assign s_c   = S_W'(s2);

	always_comb begin
		if (a_c == '0)
			code_c = (s2 == '0) ? SC_ZERO : SC_RIGHT;
		else if (s2 == '0)
			code_c = c[aik_pkg::C_W-1] ? SC_HALF : SC_ZERO;
		else
			code_c = SC_NONE;
	end

	// normalising shift search, one binary weight a stage
	logic [A_W-1:0] na_q    [0:NS];
	logic [S_W-1:0] ns_q    [0:NS];
	logic           nneg_q  [0:NS];
	short_t         ncode_q [0:NS];
	logic           nlow_q  [0:NS];

	always_ff @(posedge clk) begin
		na_q[0]    <= a_c;
		ns_q[0]    <= s_c;
		nneg_q[0]  <= c[aik_pkg::C_W-1];
		ncode_q[0] <= code_c;
		nlow_q[0]  <= norm_room(a_c, s_c, 0);
		for (int i = 1; i <= NS; i++) begin
			if (norm_room(na_q[i-1], ns_q[i-1], 1 << (NS - i))) begin
				na_q[i] <= na_q[i-1] << (1 << (NS - i));
				ns_q[i] <= ns_q[i-1] << (2 * (1 << (NS - i)));
			end else begin
				na_q[i] <= na_q[i-1];
				ns_q[i] <= ns_q[i-1];
			end
			nneg_q[i]  <= nneg_q[i-1];
			ncode_q[i] <= ncode_q[i-1];
			nlow_q[i]  <= nlow_q[i-1];
		end
	end

	// one more step when the word started below both limits
	logic [A_W-1:0] af_c;
	logic [S_W-1:0] sf_c;

	assign af_c = nlow_q[NS] ? (na_q[NS] << 1) : na_q[NS];
	assign sf_c = nlow_q[NS] ? (ns_q[NS] << 2) : ns_q[NS];

	// square root chain
	logic [S_W-1:0]             rad_w  [0:SQ];
	logic [aik_pkg::REM_W-1:0]  rem_w  [0:SQ];
	logic [aik_pkg::ROOT_W-1:0] root_w [0:SQ];
	logic [A_W-1:0]             sa_q    [0:SQ-1];
	logic                       sneg_q  [0:SQ-1];
	short_t                     scode_q [0:SQ-1];

	assign rad_w[0]  = sf_c;
	assign rem_w[0]  = '0;
	assign root_w[0] = '0;

	for (genvar j = 0; j < SQ; j++) begin : g_sqrt
		aik_sqrt_cell u_cell (
			.clk    (clk),
			.rad_i  (rad_w[j]),
			.rem_i  (rem_w[j]),
			.root_i (root_w[j]),
			.rad_o  (rad_w[j+1]),
			.rem_o  (rem_w[j+1]),
			.root_o (root_w[j+1])
		);
	end

	always_ff @(posedge clk) begin
		sa_q[0]    <= af_c;
		sneg_q[0]  <= nneg_q[NS];
		scode_q[0] <= ncode_q[NS];
		for (int i = 1; i < SQ; i++) begin
			sa_q[i]    <= sa_q[i-1];
			sneg_q[i]  <= sneg_q[i-1];
			scode_q[i] <= scode_q[i-1];
		end
	end

	// CORDIC chain; a negative cosine is first turned by -90 degrees
	logic signed [XY_W-1:0] cx_w [0:ITERS];
	logic signed [XY_W-1:0] cy_w [0:ITERS];
	logic signed [Z_W-1:0]  cz_w [0:ITERS];
	short_t                 ccode_q [0:ITERS];
	logic signed [XY_W-1:0] px_q;
	logic signed [XY_W-1:0] py_q;
	logic signed [Z_W-1:0]  pz_q;

	always_ff @(posedge clk) begin
		if (sneg_q[SQ-1]) begin
			px_q <= XY_W'(root_w[SQ]);
			py_q <= XY_W'(sa_q[SQ-1]);
			pz_q <= D90;
		end else begin
			px_q <= XY_W'(sa_q[SQ-1]);
			py_q <= XY_W'(root_w[SQ]);
			pz_q <= '0;
		end
		ccode_q[0] <= scode_q[SQ-1];
		for (int i = 1; i <= ITERS; i++)
			ccode_q[i] <= ccode_q[i-1];
	end

	assign cx_w[0] = px_q;
	assign cy_w[0] = py_q;
	assign cz_w[0] = pz_q;

	for (genvar k = 0; k < ITERS; k++) begin : g_cordic
		aik_cordic_cell #(
			.SHIFT (k),
			.Z_W   (Z_W),
			.STEP  (Z_W'(aik_pkg::step_angle(k, FRAC_BITS)))
		) u_cell (
			.clk (clk),
			.x_i (cx_w[k]),
			.y_i (cy_w[k]),
			.z_i (cz_w[k]),
			.x_o (cx_w[k+1]),
			.y_o (cy_w[k+1]),
			.z_o (cz_w[k+1])
		);
	end

	// result, shortcut cases override
	always_ff @(posedge clk) begin
		case (ccode_q[ITERS])
			SC_ZERO:  z <= '0;
			SC_HALF:  z <= D180;
			SC_RIGHT: z <= D90;
			default:  z <= cz_w[ITERS];
		endcase
	end

endmodule

// ===== hdl/aik_checker.sv =====
// Port level checks for the arm inverse kinematics block, bound to the top.
// Depends on aik_pkg and arm_inverse_kinematics.

module aik_checker #(
	parameter int FRAC_BITS = aik_pkg::FRAC_BITS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic signed [10:0] target_x,
	input logic signed [10:0] target_y,
	input logic [7:0]         base_angle,
	input logic signed [8:0]  shoulder_angle,
	input logic [7:0]         elbow_angle,
	input logic signed [9:0]  wrist_angle,
	input logic [1:0]         status
);

	localparam int LAT = aik_pkg::block_latency(FRAC_BITS);

	// every word taken gives a result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result word missing after latency");

	// no result without a word taken
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LAT !done)
		else $error("result word without a taken word");

	// origin target flagged
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && target_x == '0 && target_y == '0
		|-> ##LAT (status == aik_pkg::ST_ORIGIN))
		else $error("origin target not flagged");

	// failed targets carry zero angles
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != aik_pkg::ST_OK |-> base_angle == '0 && shoulder_angle == '0
		&& elbow_angle == '0 && wrist_angle == '0)
		else $error("non-zero angle on a failed target");

endmodule

bind arm_inverse_kinematics aik_checker #(.FRAC_BITS(FRAC_BITS)) u_aik_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.target_x       (target_x),
	.target_y       (target_y),
	.base_angle     (base_angle),
	.shoulder_angle (shoulder_angle),
	.elbow_angle    (elbow_angle),
	.wrist_angle    (wrist_angle),
	.status         (status)
);
